/* rtl/idsd_pkg.sv */
// Shared constants for the infrared direction selector with debounce.
// Used by the top level, queue, debouncer and checker in rtl/ through scoped names; depends on nothing.
`timescale 1ns / 1ps

package idsd_pkg;

   // Default sensor count of the array.
   localparam int SENSORS_DEFAULT = 6;

   // Debounce run counter and threshold register.
   localparam int THR_W = 4;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 4'd3;
   localparam logic [THR_W-1:0] RUN_MAX = 4'd15;

   // Front-sensor mask reset value, trimmed to the sensor count at the top level.
   localparam logic [31:0] FRONT_MASK_RESET = 32'd35;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRONT_MASK = 2'd1;

   // Depth of the queue between classifier and debouncer.
   localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/ir_direction_select_debounce.sv */
// Top level of the infrared direction selector with debounce: configuration
// registers, classifier, queue and debouncer. Depends on idsd_pkg and the idsd_ modules.
//
//   channel   dir  handshake              payload
//   req_      in   req_tvalid/req_tready  tdata: sensor_levels
//   rsp_      out  rsp_tvalid/rsp_tready  tdata: direction; tuser: signal_lost, new_direction
//   csr_      in   csr_we                 csr_index, csr_wdata
//
// One frame is accepted per cycle while the queue has room; each frame waits
// in the two-entry queue until the debouncer takes it, and a frame with a result
// is then loaded into the output register. Frames that are not yet stable produce no result.
// Synchronous reset clears the queue, run state and output valid, and
// restores threshold 3 and the front mask to its reset value.
// A stalled rsp_ side backs up through the queue to req_tready.
`timescale 1ns / 1ps

module ir_direction_select_debounce #(
   parameter int SENSORS = idsd_pkg::SENSORS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [SENSORS-1:0] sensor_levels, zero padding above
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SENSORS+7)/8)*8-1:0]          req_tdata,
   // rsp_tdata: [DIR_W-1:0] direction, zero padding above
   // rsp_tuser: [0] signal_lost, [1] new_direction
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [(($clog2(SENSORS)+7)/8)*8-1:0]  rsp_tdata,
   output logic [1:0]                            rsp_tuser,
   input  logic                                  csr_we,
   input  logic [idsd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [((SENSORS > 4) ? SENSORS : 4)-1:0] csr_wdata
);

   localparam int DIR_W = $clog2(SENSORS);
   localparam int RSP_W = ((DIR_W + 7) / 8) * 8;
   localparam int THR_W = idsd_pkg::THR_W;
   localparam logic [31:0] FRONT_RESET_FULL = idsd_pkg::FRONT_MASK_RESET;
   localparam logic [SENSORS-1:0] FRONT_RESET = FRONT_RESET_FULL[SENSORS-1:0];

   logic [THR_W-1:0]   threshold_ff;
   logic [SENSORS-1:0] front_mask_ff;
   logic               cls_lost;
   logic [DIR_W-1:0]   cls_cand;
   logic               q_full;
   logic               q_not_empty;
   logic               q_pop;
   logic [DIR_W:0]     q_data;
   logic               back_ready;
   logic [DIR_W-1:0]   out_direction;
   logic               out_lost;
   logic               out_new;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= idsd_pkg::THRESHOLD_RESET;
         front_mask_ff <= FRONT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            idsd_pkg::REG_RUN_THRESHOLD: threshold_ff  <= csr_wdata[THR_W-1:0];
            idsd_pkg::REG_FRONT_MASK:    front_mask_ff <= csr_wdata[SENSORS-1:0];
            default: ;
         endcase
      end
   end

   idsd_front #(
      .SENSORS (SENSORS),
      .DIR_W   (DIR_W)
   ) u_front (
      .sensor_levels (req_tdata[SENSORS-1:0]),
      .front_mask    (front_mask_ff),
      .lost          (cls_lost),
      .cand          (cls_cand)
   );

   assign req_tready = !q_full;

   idsd_queue #(
      .WIDTH (DIR_W + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !q_full),
      .push_data ({cls_lost, cls_cand}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   assign q_pop = q_not_empty && back_ready;

   idsd_back #(
      .DIR_W (DIR_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .run_threshold    (threshold_ff),
      .item_valid       (q_not_empty),
      .item_lost        (q_data[DIR_W]),
      .item_cand        (q_data[DIR_W-1:0]),
      .item_ready       (back_ready),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_direction    (out_direction),
      .out_lost         (out_lost),
      .out_new          (out_new)
   );

   assign rsp_tdata = RSP_W'(out_direction);
   assign rsp_tuser = {out_new, out_lost};

endmodule

/* rtl/idsd_front.sv */
// Classifier: turns one frame of active-low sensor levels into a candidate
// direction and a lost-signal flag. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module idsd_front #(
   parameter int SENSORS = 6,
   parameter int DIR_W = 3
) (
   input  logic [SENSORS-1:0] sensor_levels,
   input  logic [SENSORS-1:0] front_mask,
   output logic               lost,
   output logic [DIR_W-1:0]   cand
);

   localparam int CNT_W = $clog2(SENSORS + 1);

   logic [SENSORS-1:0] active;
   logic [SENSORS-1:0] front;
   logic [SENSORS-1:0] kept;
   logic [CNT_W-1:0]   target;

   // Pick active front sensors if any, otherwise all active sensors
   assign active = ~sensor_levels;
   assign front  = active & front_mask;
   assign kept   = (front != '0) ? front : active;
   assign lost   = (active == '0);
   assign target = CNT_W'($countones(kept)) >> 1;

   // Select the kept sensor with exactly target kept sensors below it
   always_comb begin
      cand = '0;
      for (int i = 0; i < SENSORS; i++) begin
         if (kept[i] &&
             (CNT_W'($countones(kept & ~({SENSORS{1'b1}} << i))) == target)) begin
            cand = cand | DIR_W'(i);
         end
      end
   end

endmodule

/* rtl/idsd_queue.sv */
// Short item queue between the classifier and the debouncer.
// Depends on idsd_pkg for its depth.
`timescale 1ns / 1ps

module idsd_queue #(
   parameter int WIDTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = idsd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/idsd_back.sv */
// Debouncer: tracks runs of equal candidates, issues stable directions and
// lost-signal reports into an output register. Depends on idsd_pkg.
`timescale 1ns / 1ps

module idsd_back #(
   parameter int DIR_W = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [idsd_pkg::THR_W-1:0]    run_threshold,
   input  logic                          item_valid,
   input  logic                          item_lost,
   input  logic [DIR_W-1:0]              item_cand,
   output logic                          item_ready,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [DIR_W-1:0]              out_direction,
   output logic                          out_lost,
   output logic                          out_new
);

   localparam int THR_W = idsd_pkg::THR_W;

   logic             take;
   logic [DIR_W-1:0] last_ff, last_in;
   logic             last_valid_ff, last_valid_in;
   logic [DIR_W-1:0] comm_ff, comm_in;
   logic             comm_valid_ff, comm_valid_in;
   logic [THR_W-1:0] run_ff, run_in;
   logic             emit;
   logic             is_new;

   logic             out_valid_ff, out_valid_in;
   logic [DIR_W-1:0] out_dir_ff, out_dir_in;
   logic             out_lost_ff, out_lost_in;
   logic             out_new_ff, out_new_in;

   // Take an item whenever the output register is free or being drained
   assign item_ready = !out_valid_ff || out_ready;
   assign take       = item_valid && item_ready;

   // Update run state and decide whether a result goes out
   always_comb begin
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      comm_in       = comm_ff;
      comm_valid_in = comm_valid_ff;
      run_in        = run_ff;
      emit          = 1'b0;
      is_new        = 1'b0;
      if (item_lost) begin
         last_valid_in = 1'b0;
         comm_valid_in = 1'b0;
         run_in        = '0;
         emit          = 1'b1;
      end else begin
         if (last_valid_ff && (item_cand == last_ff)) begin
            run_in = (run_ff == idsd_pkg::RUN_MAX) ? run_ff : run_ff + 1'b1;
         end else begin
            run_in = THR_W'(1);
         end
         last_in       = item_cand;
         last_valid_in = 1'b1;
         if (run_in >= run_threshold) begin
            emit          = 1'b1;
            is_new        = !comm_valid_ff || (item_cand != comm_ff);
            comm_in       = item_cand;
            comm_valid_in = 1'b1;
         end
      end
   end

   // Load the output register on a take that issues a result, clear it once drained
   always_comb begin
      out_valid_in = out_valid_ff;
      out_dir_in   = out_dir_ff;
      out_lost_in  = out_lost_ff;
      out_new_in   = out_new_ff;
      if (item_ready) begin
         out_valid_in = take && emit;
      end
      if (take && emit) begin
         out_dir_in  = item_lost ? '0 : item_cand;
         out_lost_in = item_lost;
         out_new_in  = is_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
         comm_valid_ff <= 1'b0;
         run_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            last_valid_ff <= last_valid_in;
            comm_valid_ff <= comm_valid_in;
            run_ff        <= run_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload registers without reset
   always_ff @(posedge clock) begin
      if (take) begin
         last_ff <= last_in;
         comm_ff <= comm_in;
      end
      out_dir_ff  <= out_dir_in;
      out_lost_ff <= out_lost_in;
      out_new_ff  <= out_new_in;
   end

   assign out_valid     = out_valid_ff;
   assign out_direction = out_dir_ff;
   assign out_lost      = out_lost_ff;
   assign out_new       = out_new_ff;

endmodule

/* rtl/idsd_checker.sv */
// Port-level checks for ir_direction_select_debounce, attached by bind.
// Depends on idsd_pkg for the default sensor count and the configuration index width.
`timescale 1ns / 1ps

module idsd_checker #(
   parameter int SENSORS = idsd_pkg::SENSORS_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [((SENSORS+7)/8)*8-1:0]          req_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [(($clog2(SENSORS)+7)/8)*8-1:0]  rsp_tdata,
   input logic [1:0]                            rsp_tuser,
   input logic                                  csr_we,
   input logic [idsd_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [((SENSORS > 4) ? SENSORS : 4)-1:0] csr_wdata
);

   localparam int RSP_W = (($clog2(SENSORS) + 7) / 8) * 8;

   // No result is offered in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A lost-signal report carries direction 0 and no new flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> ((rsp_tdata == '0) && !rsp_tuser[1]))
      else $error("lost-signal report with direction or new flag");

   // Issued directions name an existing sensor
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata < RSP_W'(SENSORS)))
      else $error("direction out of range");

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind ir_direction_select_debounce idsd_checker #(.SENSORS(SENSORS)) u_idsd_checker (.*);

/* tb/ir_heading_checker.sv */
// Checker for the IR direction selector: watches the request, result and CSR ports,
// predicts each issued heading and compares it against the block's output.
// Depends on idsd_pkg for the sensor count, register indexes, reset values and debounce widths.
`timescale 1ns / 1ps

module ir_heading_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [5:0] sensor_levels
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [7:0]                     rsp_tdata,   // [2:0] direction
   input  logic [1:0]                     rsp_tuser,   // [0] signal_lost, [1] new_direction
   input  logic                           csr_we,
   input  logic [idsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [5:0]                     csr_wdata,
   output int                             heading_pending,
   output int                             fail_count
);

   localparam int NS = idsd_pkg::SENSORS_DEFAULT;
   localparam int THR_W = idsd_pkg::THR_W;
   localparam logic [2:0] NO_DIR = 3'd7;

   typedef struct packed {
      logic [2:0] direction;
      logic       signal_lost;
      logic       new_direction;
   } heading_type;

   heading_type heading_due[$];
   int pend = 0;
   int fails = 0;

   // Mirror of the CSRs and the debounce state
   logic [THR_W-1:0] thr_cfg;
   logic [NS-1:0]    front_cfg;
   logic [2:0]       prev_cand;
   logic             prev_valid;
   logic [2:0]       held_dir;
   logic             held_valid;
   logic [THR_W-1:0] run_len;

   assign heading_pending = pend;
   assign fail_count = fails;

   task automatic report_mismatch(input string what, input int want_v, input int got_v);
      $display("MISMATCH @%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
      fails++;
   endtask

   // Pick the kept sensor at position count/2, lowest index first
   function automatic logic [2:0] middle_of(input logic [NS-1:0] kept);
      int total;
      int seen;
      logic [2:0] pick;
      total = $countones(kept);
      seen = 0;
      pick = '0;
      for (int i = 0; i < NS; i++) begin
         if (kept[i]) begin
            if (seen == total / 2) pick = 3'(i);
            seen++;
         end
      end
      return pick;
   endfunction

   // Advance the debounce state by one frame; return 1 when a heading is issued
   function automatic bit predict_heading(input logic [NS-1:0] levels,
                                          output heading_type h);
      logic [NS-1:0] active;
      logic [NS-1:0] front;
      logic [NS-1:0] kept;
      logic [2:0]    cand;
      active = ~levels;
      front = active & front_cfg;
      h = '0;
      if (active == '0) begin
         prev_cand = NO_DIR;
         prev_valid = 1'b0;
         held_dir = NO_DIR;
         held_valid = 1'b0;
         run_len = '0;
         h.signal_lost = 1'b1;
         return 1'b1;
      end
      kept = (front != '0) ? front : active;
      cand = middle_of(kept);
      if (prev_valid && cand == prev_cand) begin
         if (run_len != idsd_pkg::RUN_MAX) run_len++;
      end else begin
         run_len = THR_W'(1);
         prev_cand = cand;
         prev_valid = 1'b1;
      end
      if (run_len < thr_cfg) return 1'b0;
      h.direction = cand;
      h.new_direction = !held_valid || cand != held_dir;
      held_dir = cand;
      held_valid = 1'b1;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      heading_type got;
      heading_type want;
      if (reset) begin
         thr_cfg = idsd_pkg::THRESHOLD_RESET;
         front_cfg = idsd_pkg::FRONT_MASK_RESET[NS-1:0];
         prev_cand = NO_DIR;
         prev_valid = 1'b0;
         held_dir = NO_DIR;
         held_valid = 1'b0;
         run_len = '0;
         heading_due.delete();
      end else begin
         // Check the result first so a fresh expectation cannot hide a stray one
         if (rsp_tvalid && rsp_tready) begin
            got.direction = rsp_tdata[2:0];
            got.signal_lost = rsp_tuser[0];
            got.new_direction = rsp_tuser[1];
            if (heading_due.size() == 0) begin
               report_mismatch("result with nothing pending, direction", -1, got.direction);
            end else begin
               want = heading_due.pop_front();
               if (got.direction !== want.direction)
                  report_mismatch("direction", want.direction, got.direction);
               if (got.signal_lost !== want.signal_lost)
                  report_mismatch("signal_lost", want.signal_lost, got.signal_lost);
               if (got.new_direction !== want.new_direction)
                  report_mismatch("new_direction", want.new_direction, got.new_direction);
            end
         end
         if (req_tvalid && req_tready) begin
            if (predict_heading(req_tdata[NS-1:0], want)) heading_due.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               idsd_pkg::REG_RUN_THRESHOLD: thr_cfg = csr_wdata[THR_W-1:0];
               idsd_pkg::REG_FRONT_MASK:    front_cfg = csr_wdata[NS-1:0];
               default: ;
            endcase
         end
      end
      pend = heading_due.size();
   end

endmodule

/* tb/ir_direction_select_debounce_tb.sv */
// Top of the IR direction selector testbench: clock, reset, frame and CSR stimulus,
// result back-pressure and the verdict. Depends on idsd_pkg, the RTL and ir_heading_checker.
`timescale 1ns / 1ps

module ir_direction_select_debounce_tb;

   localparam int CSR_IDX_W = idsd_pkg::CSR_IDX_W;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam logic [5:0] NO_SENSOR = 6'h3F;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = idsd_pkg::REG_FRONT_MASK + 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // [5:0] sensor_levels, zero padding above
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [2:0] direction, zero padding above
   logic [1:0]           rsp_tuser;        // [0] signal_lost, [1] new_direction
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = idsd_pkg::REG_RUN_THRESHOLD;
   logic [5:0]           csr_wdata = '0;

   int heading_pending;
   int fail_count;
   int cycle_count = 0;
   int tx_gap_pct = 16;
   int rx_stall_pct = 16;
   int run_thr = idsd_pkg::THRESHOLD_RESET;
   int hold_asked = 0;
   int hold_done = 0;

   ir_direction_select_debounce uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ir_heading_checker heading_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .heading_pending(heading_pending), .fail_count(fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_asked != hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done++;
         end
         rsp_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Offer one frame and hold it until accepted; called and returns at a falling edge
   task automatic send_frame(input logic [5:0] levels);
      while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, levels};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [5:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Drop valid, wait for every pending heading, then let in-flight frames drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (heading_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int thr, input logic [5:0] mask);
      write_reg(REG_SPARE_LO, 6'($urandom));
      write_reg(idsd_pkg::REG_RUN_THRESHOLD, {2'($urandom_range(3)), 4'(thr)});
      write_reg(idsd_pkg::REG_FRONT_MASK, mask);
      write_reg(REG_SPARE_HI, 6'($urandom));
      csr_we <= 1'b0;
      run_thr = thr;
   endtask

   // Mostly held patterns around the threshold, some long runs, lost frames and noise
   task automatic run_burst(input int n);
      int sent;
      int len;
      int pick;
      logic [5:0] levels;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         levels = 6'($urandom);
         if (pick < 70) begin
            len = (pick < 7) ? $urandom_range(16, 24) : $urandom_range(1, run_thr + 3);
            repeat (len) send_frame(levels);
            sent += len;
         end else if (pick < 80) begin
            send_frame(NO_SENSOR);
            sent++;
         end else begin
            send_frame(levels);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed frames at reset settings: loss, front priority, side only, single sensors
      send_frame(NO_SENSOR);
      repeat (4) send_frame(6'h00);
      repeat (3) send_frame(6'h23);
      repeat (3) send_frame(6'h3E);
      repeat (3) send_frame(6'h1F);
      send_frame(NO_SENSOR);
      send_frame(6'h15);
      send_frame(6'h2A);
      settle();

      // Every sensor in front, no idling on either side
      tx_gap_pct = 0;
      rx_stall_pct = 0;
      configure(1, 6'h3F);
      run_burst(200);
      settle();

      // Reset-like settings with a long result hold-off mid-stream
      tx_gap_pct = 16;
      rx_stall_pct = 16;
      configure(3, 6'h23);
      run_burst(100);
      hold_asked++;
      run_burst(200);
      settle();

      // Highest threshold, no front sensors
      configure(15, 6'h00);
      run_burst(250);
      settle();

      // Zero threshold behaves as one
      configure(0, 6'($urandom));
      run_burst(200);
      settle();

      configure($urandom_range(2, 14), 6'($urandom));
      run_burst(200);
      settle();

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/idsd_pkg.sv
rtl/idsd_front.sv
rtl/idsd_queue.sv
rtl/idsd_back.sv
rtl/ir_direction_select_debounce.sv
rtl/idsd_checker.sv
tb/ir_heading_checker.sv
tb/ir_direction_select_debounce_tb.sv
